// ===== design/cht_pkg.sv =====
// Shared constants for the chained hash table.
package cht_pkg;
	localparam int unsigned BUCKETS_DEF = 1024;
	localparam int unsigned MODULUS_DEF = 1021;
	localparam int unsigned NODES_DEF   = 4096;
	localparam int unsigned KEY_W       = 64;
	localparam int unsigned POS_W       = 32;
	localparam logic        KIND_INSERT = 1'b0;
	localparam logic        KIND_LOOKUP = 1'b1;
endpackage

// ===== design/cht_if.sv =====
// Request and response channel interfaces of the chained hash table.
interface cht_req_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [cht_pkg::KEY_W-1:0]   key;
	modport source (output valid, kind, key, input ready);
	modport sink   (input valid, kind, key, output ready);
endinterface

interface cht_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [cht_pkg::POS_W-1:0]   position;
	logic                        full_res;
	modport source (output valid, hit, position, full_res, input ready);
	modport sink   (input valid, hit, position, full_res, output ready);
endinterface

// ===== design/cht_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/chained_hash_table.sv =====
// Chained hash table top level: bucket heads and node pool in RAM, chain walker FSM.
// Each word hashes its key as key mod MODULUS four bits a cycle, reduces the hash mod
// BUCKETS bit by bit when MODULUS > BUCKETS, reads the bucket head through the issue
// and head states, visits the chain nodes in order on the node RAM read port, and
// finishes in the done state once the response register is free. After reset a
// clearing pass empties the bucket head RAM; no word is taken meanwhile.
// An insert of a new key with the pool full returns full_res and is dropped.
module chained_hash_table #(
	parameter int unsigned BUCKETS = cht_pkg::BUCKETS_DEF,
	parameter int unsigned MODULUS = cht_pkg::MODULUS_DEF,
	parameter int unsigned NODES   = cht_pkg::NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cht_req_if.sink     req,
	cht_rsp_if.source   rsp
);
	localparam int unsigned MW     = $clog2(MODULUS);
	localparam int unsigned BAW    = $clog2(BUCKETS);
	localparam int unsigned NAW    = $clog2(NODES);
	localparam int unsigned NW     = $clog2(NODES + 1);
	localparam int unsigned RCW    = $clog2(MW + 1);
	localparam int unsigned KW     = cht_pkg::KEY_W;
	localparam int unsigned PW     = cht_pkg::POS_W;
	localparam int unsigned NODE_W = KW + PW + NW;
	localparam bit          DO_RED = (MODULUS > BUCKETS);
	localparam logic [MW:0]  MODV  = (MW + 1)'(MODULUS);
	localparam logic [BAW:0] BV    = (BAW + 1)'(BUCKETS);
	localparam logic [NW-1:0] EMPTY = NW'(NODES);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_HASH, S_RED, S_ISSUE, S_HEAD, S_NODE, S_DONE
	} state_t;

	state_t            state_q;
	logic [BAW-1:0]    clr_q;
	logic              kind_q;
	logic [KW-1:0]     key_q;
	logic [KW-1:0]     ksh_q;
	logic [3:0]        cnt_q;
	logic [MW-1:0]     h_q;
	logic [MW-1:0]     hs_q;
	logic [RCW-1:0]    rcnt_q;
	logic [BAW-1:0]    bkt_q;
	logic [NW-1:0]     head_q;
	logic              hit_q;
	logic [PW-1:0]     pos_q;
	logic [NW-1:0]     used_q;
	logic [PW-1:0]     idx_q;
	logic              ov_q;
	logic              ohit_q;
	logic [PW-1:0]     opos_q;
	logic              ofull_q;

	logic [MW:0]       t;
	logic [MW-1:0]     hn;
	logic [BAW:0]      u;
	logic [BAW-1:0]    bn;
	logic              hd_we;
	logic [BAW-1:0]    hd_waddr;
	logic [NW-1:0]     hd_wdata;
	logic [NW-1:0]     hd_rdata;
	logic              nd_we;
	logic [NAW-1:0]    nd_raddr;
	logic [NODE_W-1:0] nd_rdata;
	logic [KW-1:0]     nd_key;
	logic [PW-1:0]     nd_pos;
	logic [NW-1:0]     nd_next;
	logic              fin;
	logic              add;

	always_comb begin
		hn = h_q;
		t  = '0;
		for (int i = 3; i >= 0; i--) begin
			t = {hn, ksh_q[KW-4+i]};
			if (t >= MODV) begin
				t = t - MODV;
			end
			hn = t[MW-1:0];
		end
	end

	always_comb begin
		u = {bkt_q, hs_q[MW-1]};
		if (u >= BV) begin
			u = u - BV;
		end
		bn = u[BAW-1:0];
	end

	assign {nd_key, nd_pos, nd_next} = nd_rdata;
	assign fin = (state_q == S_DONE) && (!ov_q || rsp.ready);
	assign add = fin && !hit_q && (kind_q == cht_pkg::KIND_INSERT) && (used_q < EMPTY);

	assign hd_we    = (state_q == S_CLR) || add;
	assign hd_waddr = (state_q == S_CLR) ? clr_q : bkt_q;
	assign hd_wdata = (state_q == S_CLR) ? EMPTY : used_q;
	assign nd_we    = add;
	assign nd_raddr = (state_q == S_HEAD) ? hd_rdata[NAW-1:0] : nd_next[NAW-1:0];

	cht_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
		.clk   (clk),
		.we    (hd_we),
		.waddr (hd_waddr),
		.wdata (hd_wdata),
		.raddr (bkt_q),
		.rdata (hd_rdata)
	);

	cht_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node (
		.clk   (clk),
		.we    (nd_we),
		.waddr (used_q[NAW-1:0]),
		.wdata ({key_q, idx_q, head_q}),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = ov_q;
	assign rsp.hit      = ohit_q;
	assign rsp.position = opos_q;
	assign rsp.full_res = ofull_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			used_q  <= '0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
			rcnt_q  <= '0;
		end else begin
			ov_q <= fin || (ov_q && !rsp.ready);
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BAW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						kind_q  <= req.kind;
						key_q   <= req.key;
						ksh_q   <= req.key;
						h_q     <= '0;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					h_q   <= hn;
					ksh_q <= ksh_q << 4;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'hF) begin
						if (DO_RED) begin
							hs_q    <= hn;
							bkt_q   <= '0;
							rcnt_q  <= '0;
							state_q <= S_RED;
						end else begin
							bkt_q   <= BAW'(hn);
							state_q <= S_ISSUE;
						end
					end
				end
				S_RED: begin
					bkt_q  <= bn;
					hs_q   <= hs_q << 1;
					rcnt_q <= rcnt_q + 1'b1;
					if (rcnt_q == RCW'(MW - 1)) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					head_q <= hd_rdata;
					if (hd_rdata < used_q) begin
						state_q <= S_NODE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_NODE: begin
					if (nd_key == key_q) begin
						hit_q   <= 1'b1;
						pos_q   <= nd_pos;
						state_q <= S_DONE;
					end else if (!(nd_next < used_q)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (fin) begin
						ohit_q <= hit_q;
						if (hit_q) begin
							opos_q  <= pos_q;
							ofull_q <= 1'b0;
						end else if (kind_q == cht_pkg::KIND_INSERT) begin
							if (used_q < EMPTY) begin
								opos_q  <= idx_q;
								ofull_q <= 1'b0;
								used_q  <= used_q + 1'b1;
							end else begin
								opos_q  <= '0;
								ofull_q <= 1'b1;
							end
						end else begin
							opos_q  <= '0;
							ofull_q <= 1'b0;
						end
						if (kind_q == cht_pkg::KIND_INSERT) begin
							idx_q <= idx_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== design/cht_checker.sv =====
// Port-level assertions for the chained hash table, bound to the top level.
module cht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        hit,
	input logic [31:0] position,
	input logic        full_res
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(position) && $stable(hit) && $stable(full_res))
		else $error("response payload changed while stalled");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && full_res |-> !hit && position == 32'd0)
		else $error("full response carries hit or position");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");
endmodule

bind chained_hash_table cht_checker u_cht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.hit       (rsp.hit),
	.position  (rsp.position),
	.full_res  (rsp.full_res)
);
